### rtl/mlps_pkg.sv
// ----------------------------------------------------------------------------
// mlps_pkg
// Types and codes shared by the point list store modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mlps_pkg;

   // Operation codes as they arrive on the request channel.
   typedef enum logic [2:0] {
      OP_APPEND = 3'd0,
      OP_READ   = 3'd1,
      OP_WRITE  = 3'd2,
      OP_INSERT = 3'd3,
      OP_REMOVE = 3'd4,
      OP_RANGE  = 3'd5,
      OP_FIND   = 3'd6,
      OP_NONE   = 3'd7
   } op_type;

   // Classified command handed from the front end to the engine.
   typedef struct packed {
      op_type      op;
      logic        id_ok;
      logic [3:0]  list_id;
      logic [11:0] position;
      logic [12:0] range_length;
      logic [15:0] point_x;
      logic [15:0] point_y;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MOVE,
      ST_FIND,
      ST_READW,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

### rtl/mlps_req_if.sv
// ----------------------------------------------------------------------------
// mlps_req_if
// Request channel of the point list store: valid, ready and one request.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlps_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [3:0]  list_id;
   logic [11:0] position;
   logic [12:0] range_length;
   logic [15:0] point_x;
   logic [15:0] point_y;

   modport source (output valid, opcode, list_id, position, range_length, point_x,
                   point_y, input ready);
   modport sink   (input valid, opcode, list_id, position, range_length, point_x,
                   point_y, output ready);
endinterface

`default_nettype wire

### rtl/mlps_rsp_if.sv
// ----------------------------------------------------------------------------
// mlps_rsp_if
// Response channel of the point list store: valid, ready and one response.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlps_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] read_x;
   logic [15:0] read_y;
   logic [12:0] list_length;
   logic [11:0] found_index;
   logic        found;
   logic        full_drop;

   modport source (output valid, read_x, read_y, list_length, found_index, found,
                   full_drop, input ready);
   modport sink   (input valid, read_x, read_y, list_length, found_index, found,
                   full_drop, output ready);
endinterface

`default_nettype wire

### rtl/mlps_front.sv
// ----------------------------------------------------------------------------
// mlps_front
// Accepts requests, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mlps_front #(
   parameter int NUM_LISTS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   mlps_req_if.sink               req_ch,
   output mlps_pkg::cmd_type      q_data,
   output logic                   q_valid,
   input  wire logic              q_pop
);
   import mlps_pkg::*;

   cmd_type     slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   cmd_type     cmd_new;
   logic        push;
   logic        pop;
   logic [31:0] id_ext;

   assign req_ch.ready = (fill_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign q_valid      = (fill_ff != 2'd0);
   assign pop          = q_pop && q_valid;
   assign q_data       = slot_ff[rd_ptr_ff];

   always_comb begin
      id_ext               = {28'd0, req_ch.list_id};
      cmd_new.op           = op_type'(req_ch.opcode);
      cmd_new.id_ok        = (id_ext < NUM_LISTS);
      cmd_new.list_id      = req_ch.list_id;
      cmd_new.position     = req_ch.position;
      // A single remove is a range removal of one entry.
      cmd_new.range_length = (cmd_new.op == OP_REMOVE) ? 13'd1 : req_ch.range_length;
      cmd_new.point_x      = req_ch.point_x;
      cmd_new.point_y      = req_ch.point_y;
      wr_ptr_in            = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in            = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in              = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

`default_nettype wire

### rtl/mlps_engine.sv
// ----------------------------------------------------------------------------
// mlps_engine
// Carries out one command at a time on the point memory and the counts.
// ----------------------------------------------------------------------------
`default_nettype none

module mlps_engine #(
   parameter int NUM_LISTS     = 16,
   parameter int LIST_CAPACITY = 4096,
   parameter int COORD_BITS    = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mlps_pkg::cmd_type q_data,
   input  wire logic              q_valid,
   output logic                   q_pop,
   mlps_rsp_if.source             rsp_ch
);
   import mlps_pkg::*;

   localparam int ID_W  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int IDX_W = $clog2(LIST_CAPACITY);
   localparam int CNT_W = $clog2(LIST_CAPACITY + 1);
   localparam int AW    = ID_W + IDX_W;
   localparam int DW    = 2 * COORD_BITS;
   localparam int SW    = CNT_W + 14;

   logic [DW-1:0]    store_mem [2**AW];
   logic [DW-1:0]    rdata_ff;

   logic [CNT_W-1:0] counts_ff [NUM_LISTS];

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] src_ff, src_in;
   logic [IDX_W-1:0] dst_ff, dst_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic             up_ff, up_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic             chk_ff, chk_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [15:0]      res_x_ff, res_x_in;
   logic [15:0]      res_y_ff, res_y_in;
   logic [CNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic [11:0]      res_fidx_ff, res_fidx_in;
   logic             res_fnd_ff, res_fnd_in;
   logic             res_drop_ff, res_drop_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_x_ff, rsp_y_ff;
   logic [12:0]      rsp_len_ff;
   logic [11:0]      rsp_fidx_ff;
   logic             rsp_fnd_ff, rsp_drop_ff;
   logic             rsp_load;

   logic             mem_we, mem_re;
   logic [IDX_W-1:0] mem_widx, mem_ridx;
   logic [DW-1:0]    mem_wdata;
   logic             cnt_we;

   logic [ID_W-1:0]     id_idx, q_id_idx;
   logic [ID_W+3:0]     id_ext, q_id_ext;
   logic [COORD_BITS+15:0] px_ext, py_ext, rx_ext, ry_ext;
   logic [DW-1:0]       pt;
   logic [SW-1:0]       pos_w, len_w, cnt_w, cap_w, end_w;
   logic [IDX_W-1:0]    pos_idx;
   logic [IDX_W+11:0]   fidx_ext;
   logic [CNT_W+12:0]   len_ext;
   logic                rsp_free;
   logic                hit;

   always_comb begin
      id_ext   = {{ID_W{1'b0}}, cmd_ff.list_id};
      id_idx   = id_ext[ID_W-1:0];
      q_id_ext = {{ID_W{1'b0}}, q_data.list_id};
      q_id_idx = q_id_ext[ID_W-1:0];
      px_ext   = {16'd0, cmd_ff.point_x};
      py_ext   = {16'd0, cmd_ff.point_y};
      pt       = {py_ext[COORD_BITS-1:0], px_ext[COORD_BITS-1:0]};
      rx_ext   = {16'd0, rdata_ff[COORD_BITS-1:0]};
      ry_ext   = {16'd0, rdata_ff[DW-1:COORD_BITS]};
      pos_w    = SW'(cmd_ff.position);
      len_w    = SW'(cmd_ff.range_length);
      cnt_w    = SW'(cnt_ff);
      cap_w    = SW'(LIST_CAPACITY);
      end_w    = pos_w + len_w;
      pos_idx  = pos_w[IDX_W-1:0];
      fidx_ext = {12'd0, chk_idx_ff};
      len_ext  = {13'd0, res_cnt_ff};
      hit      = chk_ff && (rdata_ff == pt);
      rsp_free = !rsp_valid_ff || rsp_ch.ready;
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      cnt_in      = cnt_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      rem_in      = rem_ff;
      up_in       = up_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      chk_in      = 1'b0;
      chk_idx_in  = chk_idx_ff;
      res_x_in    = res_x_ff;
      res_y_in    = res_y_ff;
      res_cnt_in  = res_cnt_ff;
      res_fidx_in = res_fidx_ff;
      res_fnd_in  = res_fnd_ff;
      res_drop_in = res_drop_ff;
      q_pop       = 1'b0;
      mem_we      = 1'b0;
      mem_widx    = pos_idx;
      mem_wdata   = pt;
      mem_re      = 1'b0;
      mem_ridx    = pos_idx;
      cnt_we      = 1'b0;
      rsp_load    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               cmd_in      = q_data;
               cnt_in      = q_data.id_ok ? counts_ff[q_id_idx] : '0;
               res_x_in    = '0;
               res_y_in    = '0;
               res_fidx_in = '0;
               res_fnd_in  = 1'b0;
               res_drop_in = 1'b0;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_cnt_in = cnt_ff;
            state_in   = ST_DONE;
            if (cmd_ff.id_ok) begin
               unique case (cmd_ff.op)
                  OP_APPEND, OP_INSERT: begin
                     if (cnt_w >= cap_w) begin
                        res_drop_in = 1'b1;
                     end else if (cmd_ff.op == OP_INSERT && pos_w < cnt_w) begin
                        src_in     = IDX_W'(cnt_w - SW'(1));
                        dst_in     = IDX_W'(cnt_w);
                        rem_in     = CNT_W'(cnt_w - pos_w);
                        up_in      = 1'b1;
                        res_cnt_in = CNT_W'(cnt_w + SW'(1));
                        state_in   = ST_MOVE;
                     end else begin
                        mem_we     = 1'b1;
                        mem_widx   = IDX_W'(cnt_w);
                        res_cnt_in = CNT_W'(cnt_w + SW'(1));
                     end
                  end
                  OP_READ: begin
                     if (pos_w < cnt_w) begin
                        mem_re   = 1'b1;
                        state_in = ST_READW;
                     end
                  end
                  OP_WRITE: begin
                     mem_we = (pos_w < cnt_w);
                  end
                  OP_REMOVE, OP_RANGE: begin
                     if (pos_w < cnt_w && len_w != '0) begin
                        if (end_w < cnt_w) begin
                           src_in     = IDX_W'(end_w);
                           dst_in     = pos_idx;
                           rem_in     = CNT_W'(cnt_w - end_w);
                           up_in      = 1'b0;
                           res_cnt_in = CNT_W'(cnt_w - len_w);
                           state_in   = ST_MOVE;
                        end else begin
                           res_cnt_in = CNT_W'(pos_w);
                        end
                     end
                  end
                  OP_FIND: begin
                     src_in   = '0;
                     rem_in   = cnt_ff;
                     state_in = ST_FIND;
                  end
                  default: begin
                  end
               endcase
            end else begin
               res_cnt_in = '0;
            end
         end
         ST_MOVE: begin
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_widx  = pend_idx_ff;
               mem_wdata = rdata_ff;
            end
            if (rem_ff != '0) begin
               mem_re      = 1'b1;
               mem_ridx    = src_ff;
               pend_in     = 1'b1;
               pend_idx_in = dst_ff;
               src_in      = up_ff ? src_ff - IDX_W'(1) : src_ff + IDX_W'(1);
               dst_in      = up_ff ? dst_ff - IDX_W'(1) : dst_ff + IDX_W'(1);
               rem_in      = rem_ff - CNT_W'(1);
            end else if (!pend_ff) begin
               // Shift finished: an insert now places its point in the gap.
               mem_we   = up_ff;
               state_in = ST_DONE;
            end
         end
         ST_FIND: begin
            if (hit) begin
               res_fnd_in  = 1'b1;
               res_fidx_in = fidx_ext[11:0];
               state_in    = ST_DONE;
            end else if (rem_ff != '0) begin
               mem_re     = 1'b1;
               mem_ridx   = src_ff;
               chk_in     = 1'b1;
               chk_idx_in = src_ff;
               src_in     = src_ff + IDX_W'(1);
               rem_in     = rem_ff - CNT_W'(1);
            end else if (!chk_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_READW: begin
            res_x_in = rx_ext[15:0];
            res_y_in = ry_ext[15:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               cnt_we   = cmd_ff.id_ok;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cnt_we) begin
            counts_ff[id_idx] <= res_cnt_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      cnt_ff      <= cnt_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      rem_ff      <= rem_in;
      up_ff       <= up_in;
      pend_idx_ff <= pend_idx_in;
      chk_idx_ff  <= chk_idx_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      res_cnt_ff  <= res_cnt_in;
      res_fidx_ff <= res_fidx_in;
      res_fnd_ff  <= res_fnd_in;
      res_drop_ff <= res_drop_in;
      if (rsp_load) begin
         rsp_x_ff    <= res_x_ff;
         rsp_y_ff    <= res_y_ff;
         rsp_len_ff  <= len_ext[12:0];
         rsp_fidx_ff <= res_fidx_ff;
         rsp_fnd_ff  <= res_fnd_ff;
         rsp_drop_ff <= res_drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[{id_idx, mem_widx}] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= store_mem[{id_idx, mem_ridx}];
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_x      = rsp_x_ff;
   assign rsp_ch.read_y      = rsp_y_ff;
   assign rsp_ch.list_length = rsp_len_ff;
   assign rsp_ch.found_index = rsp_fidx_ff;
   assign rsp_ch.found       = rsp_fnd_ff;
   assign rsp_ch.full_drop   = rsp_drop_ff;

endmodule

`default_nettype wire

### rtl/multi_list_point_store_core.sv
// ----------------------------------------------------------------------------
// multi_list_point_store_core
// Several ordered lists of (x,y) points with append, read, write, insert,
// remove, range removal and search.
// ----------------------------------------------------------------------------
// Each request addresses one list and yields exactly one response carrying
// that list's count afterwards. A front end takes requests into a two-entry
// queue, so a new request is accepted while the engine is busy or while a
// response waits to be taken. The engine handles one request at a time on a
// simple dual-port point memory (one write and one read address per cycle,
// read data registered). Append, write and no-operation go from the queue
// through the execute state to the response register; a read also passes
// through a wait state for the registered read data. Insert and removal
// shift the later entries by one memory access a cycle, an insert moving
// them up before placing its point in the gap, a removal moving them down.
// Find scans from the start and stops at the first match or at the end.
// The point memory is not cleared after reset; only entries below a list's
// count are ever read, and the counts reset to zero, so no clearing pass is
// needed.
`default_nettype none

module multi_list_point_store_core #(
   parameter int NUM_LISTS     = 16,
   parameter int LIST_CAPACITY = 4096,
   parameter int COORD_BITS    = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   mlps_req_if.sink  req_ch,
   mlps_rsp_if.source rsp_ch
);
   import mlps_pkg::*;

   // Decoded requests waiting for the engine.
   cmd_type q_data;
   logic    q_valid;
   logic    q_pop;

   mlps_front #(
      .NUM_LISTS (NUM_LISTS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_data  (q_data),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   // The engine owns the memory, the per-list counts and the response register.
   mlps_engine #(
      .NUM_LISTS     (NUM_LISTS),
      .LIST_CAPACITY (LIST_CAPACITY),
      .COORD_BITS    (COORD_BITS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .q_data  (q_data),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

`default_nettype wire
